// ----- design/rwmv_pkg.sv -----
`default_nettype none
package rwmv_pkg;

   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned SPREAD_W = 16;

   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic clear_sum;
      logic rd_en;
      logic var_phase;
      logic latch_mean;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- design/rwmv_if.sv -----
`default_nettype none
interface rwmv_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic signed [rwmv_pkg::SAMPLE_W-1:0] rssi_sample;

   modport source (output valid, output mode, output rssi_sample, input ready);
   modport sink   (input valid, input mode, input rssi_sample, output ready);
endinterface

interface rwmv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [rwmv_pkg::SAMPLE_W-1:0] mean_level;
   logic        [rwmv_pkg::SPREAD_W-1:0] spread;

   modport source (output valid, output mean_level, output spread, input ready);
   modport sink   (input valid, input mean_level, input spread, output ready);
endinterface
`default_nettype wire

// ----- design/rwmv_ctrl.sv -----
`default_nettype none
module rwmv_ctrl #(
   parameter int unsigned LOG2_WINDOW = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_mode,
   output logic                         req_ready,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   input  wire rwmv_pkg::dp_status_type status,
   output rwmv_pkg::dp_cmd_type         cmd,
   output logic [LOG2_WINDOW-1:0]       rd_addr
);
   import rwmv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_WAIT,
      ST_MEAN,
      ST_VAR_RD,
      ST_VAR_WAIT,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [LOG2_WINDOW-1:0] count_ff;
   logic                   rsp_valid_ff;
   logic                   accept;
   logic                   last_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign last_addr = &count_ff;
   assign rd_addr   = count_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.wr_en      = accept & (req_mode == MODE_RECORD);
      cmd.clear_sum  = accept & (req_mode == MODE_REPORT);
      cmd.rd_en      = (state_ff == ST_SUM_RD) | (state_ff == ST_VAR_RD);
      cmd.var_phase  = (state_ff == ST_VAR_RD);
      cmd.latch_mean = (state_ff == ST_MEAN);
      cmd.load_out   = (state_ff == ST_FINISH) & (~rsp_valid_ff | rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               count_ff <= '0;
               if (accept && req_mode == MODE_REPORT) begin
                  state_ff <= ST_SUM_RD;
               end
            end
            ST_SUM_RD: begin
               count_ff <= count_ff + 1'b1;
               if (last_addr) begin
                  state_ff <= ST_SUM_WAIT;
               end
            end
            ST_SUM_WAIT: begin
               if (!status.pipe_busy) begin
                  state_ff <= ST_MEAN;
               end
            end
            ST_MEAN: begin
               count_ff <= '0;
               state_ff <= ST_VAR_RD;
            end
            ST_VAR_RD: begin
               count_ff <= count_ff + 1'b1;
               if (last_addr) begin
                  state_ff <= ST_VAR_WAIT;
               end
            end
            ST_VAR_WAIT: begin
               if (!status.pipe_busy) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (cmd.load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- design/rwmv_dp.sv -----
`default_nettype none
module rwmv_dp #(
   parameter int unsigned LOG2_WINDOW = 5
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rwmv_pkg::dp_cmd_type                  cmd,
   input  wire logic [LOG2_WINDOW-1:0]                rd_addr,
   input  wire logic signed [rwmv_pkg::SAMPLE_W-1:0]  wr_sample,
   output rwmv_pkg::dp_status_type                    status,
   output logic signed [rwmv_pkg::SAMPLE_W-1:0]       mean_level,
   output logic        [rwmv_pkg::SPREAD_W-1:0]       spread
);
   import rwmv_pkg::*;

   localparam int unsigned WINDOW = 1 << LOG2_WINDOW;
   localparam int unsigned SUM_W  = SAMPLE_W + LOG2_WINDOW;
   localparam int unsigned DIFF_W = SAMPLE_W + 1;
   localparam int unsigned PROD_W = 2 * DIFF_W;

   logic [SAMPLE_W-1:0]        ring_mem [WINDOW];
   logic [WINDOW-1:0]          entry_valid_ff;
   logic [LOG2_WINDOW-1:0]     write_slot_ff;

   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic                       rd_valid_ff;
   logic                       s1_valid_ff;
   logic                       s1_var_ff;
   logic                       s2_valid_ff;

   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] mean_ff;
   logic [SPREAD_W-1:0]        sq_ff;
   logic [SPREAD_W-1:0]        acc_ff;
   logic signed [SAMPLE_W-1:0] mean_out_ff;
   logic [SPREAD_W-1:0]        spread_out_ff;

   logic signed [SAMPLE_W-1:0] rd_sample;
   logic signed [SUM_W-1:0]    sample_ext;
   logic signed [SUM_W-1:0]    sum_shr;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [PROD_W-1:0]   prod;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_mem[write_slot_ff] <= wr_sample;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         write_slot_ff  <= '0;
         rd_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s1_var_ff      <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            entry_valid_ff[write_slot_ff] <= 1'b1;
            write_slot_ff                 <= write_slot_ff + 1'b1;
         end
         rd_valid_ff <= entry_valid_ff[rd_addr];
         s1_valid_ff <= cmd.rd_en;
         s1_var_ff   <= cmd.var_phase;
         s2_valid_ff <= s1_valid_ff & s1_var_ff;
      end
   end

   // never-written entries read as zero
   assign rd_sample  = rd_valid_ff ? signed'(rd_data_ff) : '0;
   assign sample_ext = {{LOG2_WINDOW{rd_sample[SAMPLE_W-1]}}, rd_sample};
   assign sum_shr    = sum_ff >>> LOG2_WINDOW;
   assign diff       = {rd_sample[SAMPLE_W-1], rd_sample} - {mean_ff[SAMPLE_W-1], mean_ff};
   assign prod       = diff * diff;

   always_ff @(posedge clock) begin
      if (cmd.clear_sum) begin
         sum_ff <= '0;
      end else if (s1_valid_ff && !s1_var_ff) begin
         sum_ff <= sum_ff + sample_ext;
      end
      if (cmd.latch_mean) begin
         mean_ff <= sum_shr[SAMPLE_W-1:0];
      end
      sq_ff <= prod[SPREAD_W-1:0];
      if (cmd.latch_mean) begin
         acc_ff <= '0;
      end else if (s2_valid_ff) begin
         acc_ff <= acc_ff + sq_ff;
      end
      if (cmd.load_out) begin
         mean_out_ff   <= mean_ff;
         spread_out_ff <= acc_ff;
      end
   end

   assign status.pipe_busy = s1_valid_ff | s2_valid_ff;
   assign mean_level       = mean_out_ff;
   assign spread           = spread_out_ff;

endmodule
`default_nettype wire

// ----- design/rssi_window_mean_variance.sv -----
`default_nettype none
// Sliding-window mean and spread of signal strength samples. The last
// 2**LOG2_WINDOW samples sit in a ring that reads as zero after reset. A
// record transfer (mode 0) stores one sample and gives no result. A report
// transfer (mode 1) gives one result: the floored mean of the window and the
// sum of squared deviations from it, modulo 65536. For a report, the single
// read port of the ring is walked once for the sum and once for the
// deviations before the result is offered. The result sits in an output
// register, so the next item is taken while it waits; a further report can
// finish only once that register is free.
module rssi_window_mean_variance #(
   parameter int unsigned LOG2_WINDOW = 5
) (
   input wire logic  clock,
   input wire logic  reset,
   rwmv_req_if.sink  req_chan,
   rwmv_rsp_if.source rsp_chan
);
   import rwmv_pkg::*;

   dp_cmd_type             cmd;
   dp_status_type          status;
   logic [LOG2_WINDOW-1:0] rd_addr;

   rwmv_ctrl #(
      .LOG2_WINDOW (LOG2_WINDOW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   rwmv_dp #(
      .LOG2_WINDOW (LOG2_WINDOW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_sample  (req_chan.rssi_sample),
      .status     (status),
      .mean_level (rsp_chan.mean_level),
      .spread     (rsp_chan.spread)
   );

endmodule
`default_nettype wire
